@@ design/rebq_pkg.sv @@
// ----------------------------------------------------------------------------
// rebq_pkg
// Shared widths, register indexes, mode and phase codes, and the result
// record of the rotary encoder and push-switch qualifier.
// ----------------------------------------------------------------------------
package rebq_pkg;

	localparam int CFG_W          = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int COUNTER_BITS_D = 8;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REARM_TICKS        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_HOLD_TICKS  = 2'd2;

	localparam logic [CFG_W-1:0] RST_DEBOUNCE_THRESHOLD = 8'd10;
	localparam logic [CFG_W-1:0] RST_REARM_TICKS        = 8'd20;
	localparam logic [CFG_W-1:0] RST_SWITCH_HOLD_TICKS  = 8'd30;

	localparam logic [1:0] MODE_STOPPED = 2'd0;
	localparam logic [1:0] MODE_LEFT    = 2'd1;
	localparam logic [1:0] MODE_RIGHT   = 2'd2;
	localparam logic [1:0] MODE_RELEASE = 2'd3;

	localparam logic [1:0] SW_UP       = 2'd0;
	localparam logic [1:0] SW_FALLING  = 2'd1;
	localparam logic [1:0] SW_DOWN     = 2'd2;
	localparam logic [1:0] SW_RELEASED = 2'd3;

	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;

	typedef struct packed {
		logic [1:0] step_direction;
		logic       button_press;
		logic       qualified_a;
		logic       qualified_b;
		logic       armed;
	} res_t;

endpackage

@@ design/rotary_encoder_button_qualifier.sv @@
// ----------------------------------------------------------------------------
// rotary_encoder_button_qualifier
// Qualifies raw quadrature lines into single steps and debounces the push
// switch into press pulses, one raw sample per transaction.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   line_a, line_b, switch_level
//   out      source     out_valid / out_stall step_direction, button_press,
//                                             qualified_a, qualified_b, armed
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low. The state update and result
// are one pass of logic into the result register or, while the output stalls,
// into a skid register behind it, which takes one more transaction; in_stall is
// high only while the skid register is full.
// Reset loads the register defaults and the idle, armed state.
// ----------------------------------------------------------------------------
module rotary_encoder_button_qualifier
	import rebq_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 line_a,
	input  logic                 line_b,
	input  logic                 switch_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           step_direction,
	output logic                 button_press,
	output logic                 qualified_a,
	output logic                 qualified_b,
	output logic                 armed,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
	localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};

	logic [CFG_W-1:0]        thr_q, rearm_ticks_q, hold_q;
	logic [1:0]              mode_q, phase_q;
	logic                    prev_a_q, prev_b_q, flag_a_q, flag_b_q;
	logic [COUNTER_BITS-1:0] cnt_a_q, cnt_b_q;
	logic [CFG_W-1:0]        rearm_q, sw_cnt_q;

	res_t out_q, skid_q;
	logic out_v_q, skid_v_q;

	logic                    accept, take;
	logic                    fall_a, fall_b;
	logic [1:0]              mode1, mode2, mode3, phase_n;
	logic [CFG_W-1:0]        rearm1, rearm2, sw_cnt1, sw_cnt2;
	logic [COUNTER_BITS-1:0] cnt_a_n, cnt_b_n;
	logic                    flag_a_n, flag_b_n, press;
	logic [1:0]              dir;
	res_t                    res;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_v_q;
	assign accept    = in_valid && !in_stall;
	assign take      = out_v_q && !out_stall;

	assign fall_a = prev_a_q & ~line_a;
	assign fall_b = prev_b_q & ~line_b;

	always_comb begin
		mode1 = mode_q;
		if (mode_q == MODE_STOPPED) begin
			if (fall_a) begin
				mode1 = fall_b ? MODE_RELEASE : MODE_LEFT;
			end else if (fall_b) begin
				mode1 = MODE_RIGHT;
			end
		end

		mode2  = mode1;
		rearm1 = rearm_q;
		rearm2 = rearm_q;
		if (mode1 == MODE_RELEASE) begin
			if (rearm_q != '0) begin
				rearm1 = rearm_q - CFG_W'(1);
			end
			rearm2 = rearm1;
			if (flag_a_q && flag_b_q && rearm1 == '0) begin
				mode2  = MODE_STOPPED;
				rearm2 = rearm_ticks_q;
			end
		end

		if (line_a) begin
			cnt_a_n = (cnt_a_q == COUNT_MAX) ? cnt_a_q : cnt_a_q + COUNTER_BITS'(1);
		end else begin
			cnt_a_n = '0;
		end
		if (line_b) begin
			cnt_b_n = (cnt_b_q == COUNT_MAX) ? cnt_b_q : cnt_b_q + COUNTER_BITS'(1);
		end else begin
			cnt_b_n = '0;
		end
		flag_a_n = CMP_W'(cnt_a_n) > CMP_W'(thr_q);
		flag_b_n = CMP_W'(cnt_b_n) > CMP_W'(thr_q);

		sw_cnt1 = (sw_cnt_q != '0) ? sw_cnt_q - CFG_W'(1) : sw_cnt_q;

		mode3 = mode2;
		dir   = DIR_NONE;
		if (flag_a_n && flag_b_n) begin
			if (mode2 == MODE_LEFT) begin
				mode3 = MODE_RELEASE;
				dir   = DIR_LEFT;
			end else if (mode2 == MODE_RIGHT) begin
				mode3 = MODE_RELEASE;
				dir   = DIR_RIGHT;
			end
		end

		phase_n = phase_q;
		sw_cnt2 = sw_cnt1;
		press   = 1'b0;
		unique case (phase_q)
			SW_UP: begin
				if (!switch_level) begin
					phase_n = SW_FALLING;
					sw_cnt2 = hold_q;
				end
			end
			SW_FALLING: begin
				if (!switch_level) begin
					if (sw_cnt1 == '0) begin
						press   = 1'b1;
						phase_n = SW_DOWN;
					end
				end else begin
					phase_n = SW_UP;
				end
			end
			SW_DOWN, SW_RELEASED: begin
				if (phase_q == SW_DOWN && switch_level) begin
					phase_n = SW_RELEASED;
					sw_cnt2 = hold_q;
				end
				if (switch_level) begin
					if (sw_cnt2 == '0) begin
						phase_n = SW_UP;
					end
				end else begin
					phase_n = SW_DOWN;
				end
			end
		endcase

		res.step_direction = dir;
		res.button_press   = press;
		res.qualified_a    = flag_a_n;
		res.qualified_b    = flag_b_n;
		res.armed          = (mode3 == MODE_STOPPED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= RST_DEBOUNCE_THRESHOLD;
			rearm_ticks_q <= RST_REARM_TICKS;
			hold_q        <= RST_SWITCH_HOLD_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DEBOUNCE_THRESHOLD) begin
				thr_q <= cfg_data;
			end
			if (cfg_index == REG_REARM_TICKS) begin
				rearm_ticks_q <= cfg_data;
			end
			if (cfg_index == REG_SWITCH_HOLD_TICKS) begin
				hold_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_STOPPED;
			prev_a_q <= 1'b1;
			prev_b_q <= 1'b1;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			flag_a_q <= 1'b0;
			flag_b_q <= 1'b0;
			rearm_q  <= '0;
			phase_q  <= SW_RELEASED;
			sw_cnt_q <= '0;
		end else if (accept) begin
			mode_q   <= mode3;
			prev_a_q <= line_a;
			prev_b_q <= line_b;
			cnt_a_q  <= cnt_a_n;
			cnt_b_q  <= cnt_b_n;
			flag_a_q <= flag_a_n;
			flag_b_q <= flag_b_n;
			rearm_q  <= rearm2;
			phase_q  <= phase_n;
			sw_cnt_q <= sw_cnt2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (take) begin
					skid_v_q <= 1'b0;
				end
			end else if (accept) begin
				if (!out_v_q || take) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_v_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid      = out_v_q;
	assign step_direction = out_q.step_direction;
	assign button_press   = out_q.button_press;
	assign qualified_a    = out_q.qualified_a;
	assign qualified_b    = out_q.qualified_b;
	assign armed          = out_q.armed;

endmodule

@@ bench/rebq_checker.sv @@
// ----------------------------------------------------------------------------
// rebq_checker
// Watches the sample, result and register channels of the encoder and switch
// qualifier. Keeps its own copy of the qualifier state, predicts one result
// per accepted sample and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module rebq_checker
	import rebq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 line_a,
	input  logic                 line_b,
	input  logic                 switch_level,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           step_direction,
	input  logic                 button_press,
	input  logic                 qualified_a,
	input  logic                 qualified_b,
	input  logic                 armed,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending,
	output int                   samples,
	output int                   lefts,
	output int                   rights,
	output int                   presses
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CFG_W-1:0]          thr;
	logic [CFG_W-1:0]          rearm_load;
	logic [CFG_W-1:0]          hold_len;
	logic [1:0]                mode;
	logic                      prev_a;
	logic                      prev_b;
	logic [COUNTER_BITS_D-1:0] cnt_a;
	logic [COUNTER_BITS_D-1:0] cnt_b;
	logic                      flag_a;
	logic                      flag_b;
	logic [7:0]                rearm_cnt;
	logic [1:0]                sw_phase;
	logic [7:0]                sw_cnt;
	res_t                      report_q[$];

	task automatic qualify_sample(input logic a, input logic b, input logic sw,
			output res_t r);
		logic       fall_a;
		logic       fall_b;
		logic [1:0] dir;
		logic       press;
		fall_a = prev_a & ~a;
		fall_b = prev_b & ~b;
		dir    = DIR_NONE;
		press  = 1'b0;
		prev_a = a;
		prev_b = b;

		if (mode == MODE_STOPPED) begin
			if (fall_a)
				mode = fall_b ? MODE_RELEASE : MODE_LEFT;
			else if (fall_b)
				mode = MODE_RIGHT;
		end

		if (mode == MODE_RELEASE) begin
			if (rearm_cnt != 0)
				rearm_cnt = rearm_cnt - 8'd1;
			if (flag_a && flag_b && rearm_cnt == 0) begin
				mode      = MODE_STOPPED;
				rearm_cnt = rearm_load;
			end
		end

		if (a) begin
			if (cnt_a != '1)
				cnt_a = cnt_a + 1'b1;
		end else
			cnt_a = '0;
		flag_a = cnt_a > thr;
		if (b) begin
			if (cnt_b != '1)
				cnt_b = cnt_b + 1'b1;
		end else
			cnt_b = '0;
		flag_b = cnt_b > thr;

		if (sw_cnt != 0)
			sw_cnt = sw_cnt - 8'd1;

		if (flag_a && flag_b) begin
			if (mode == MODE_LEFT) begin
				mode = MODE_RELEASE;
				dir  = DIR_LEFT;
			end else if (mode == MODE_RIGHT) begin
				mode = MODE_RELEASE;
				dir  = DIR_RIGHT;
			end
		end

		case (sw_phase)
			SW_UP: begin
				if (!sw) begin
					sw_phase = SW_FALLING;
					sw_cnt   = hold_len;
				end
			end
			SW_FALLING: begin
				if (!sw) begin
					if (sw_cnt == 0) begin
						press    = 1'b1;
						sw_phase = SW_DOWN;
					end
				end else
					sw_phase = SW_UP;
			end
			default: begin
				if (sw_phase == SW_DOWN && sw) begin
					sw_phase = SW_RELEASED;
					sw_cnt   = hold_len;
				end
				if (sw) begin
					if (sw_cnt == 0)
						sw_phase = SW_UP;
				end else
					sw_phase = SW_DOWN;
			end
		endcase

		r.step_direction = dir;
		r.button_press   = press;
		r.qualified_a    = flag_a;
		r.qualified_b    = flag_b;
		r.armed          = (mode == MODE_STOPPED);
	endtask

	task automatic compare_field(input string name, input logic [1:0] want,
			input logic [1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		if (!arst_n) begin
			thr        = RST_DEBOUNCE_THRESHOLD;
			rearm_load = RST_REARM_TICKS;
			hold_len   = RST_SWITCH_HOLD_TICKS;
			mode       = MODE_STOPPED;
			prev_a     = 1'b1;
			prev_b     = 1'b1;
			cnt_a      = '0;
			cnt_b      = '0;
			flag_a     = 1'b0;
			flag_b     = 1'b0;
			rearm_cnt  = '0;
			sw_phase   = SW_RELEASED;
			sw_cnt     = '0;
			report_q.delete();
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE_THRESHOLD: thr        = cfg_data;
					REG_REARM_TICKS:        rearm_load = cfg_data;
					REG_SWITCH_HOLD_TICKS:  hold_len   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				qualify_sample(line_a, line_b, switch_level, want);
				report_q.push_back(want);
				samples++;
				if (want.step_direction == DIR_LEFT)
					lefts++;
				if (want.step_direction == DIR_RIGHT)
					rights++;
				if (want.button_press)
					presses++;
			end
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					$display("%0t: result with no sample waiting, got dir %0d press %0d",
						$time, step_direction, button_press);
					errors++;
				end else begin
					want = report_q.pop_front();
					compare_field("step_direction", want.step_direction, step_direction);
					compare_field("button_press", 2'(want.button_press),
						2'(button_press));
					compare_field("qualified_a", 2'(want.qualified_a), 2'(qualified_a));
					compare_field("qualified_b", 2'(want.qualified_b), 2'(qualified_b));
					compare_field("armed", 2'(want.armed), 2'(armed));
				end
			end
			pending = report_q.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives quadrature detents, chatter, line noise and switch presses into the
// encoder and switch qualifier under random idling on both channels, across
// several register settings including the extremes; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rebq_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	// a, b, switch per sample, first sample in the top bits
	localparam logic [11:0] PRELUDE = {3'b001, 3'b111, 3'b010, 3'b100};
	localparam logic [59:0] OPENING = {
		3'b111, 3'b111, 3'b011, 3'b010, 3'b110, 3'b110, 3'b110, 3'b101,
		3'b111, 3'b111, 3'b001, 3'b111, 3'b111, 3'b000, 3'b100, 3'b110,
		3'b010, 3'b000, 3'b011, 3'b111
	};

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic                 line_a       = 1'b1;
	logic                 line_b       = 1'b1;
	logic                 switch_level = 1'b1;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [1:0]           step_direction;
	logic                 button_press;
	logic                 qualified_a;
	logic                 qualified_b;
	logic                 armed;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_DEBOUNCE_THRESHOLD;
	logic [CFG_W-1:0]     cfg_data     = '0;

	int errors;
	int pending;
	int samples;
	int lefts;
	int rights;
	int presses;

	int         sent     = 0;
	int         settings = 1;
	bit         calm     = 1'b0;
	logic       sw_now   = 1'b1;
	int         sw_left  = 0;
	logic [7:0] cur_thr   = RST_DEBOUNCE_THRESHOLD;
	logic [7:0] cur_rearm = RST_REARM_TICKS;
	logic [7:0] cur_hold  = RST_SWITCH_HOLD_TICKS;

	rotary_encoder_button_qualifier i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.line_a         (line_a),
		.line_b         (line_b),
		.switch_level   (switch_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_direction (step_direction),
		.button_press   (button_press),
		.qualified_a    (qualified_a),
		.qualified_b    (qualified_b),
		.armed          (armed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	rebq_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.line_a         (line_a),
		.line_b         (line_b),
		.switch_level   (switch_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_direction (step_direction),
		.button_press   (button_press),
		.qualified_a    (qualified_a),
		.qualified_b    (qualified_b),
		.armed          (armed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (errors),
		.pending        (pending),
		.samples        (samples),
		.lefts          (lefts),
		.rights         (rights),
		.presses        (presses)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic next_level(output logic lvl);
		if (sw_left == 0) begin
			sw_now  = ~sw_now;
			sw_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
				: cur_hold + $urandom_range(1, 6);
		end
		sw_left--;
		lvl = sw_now;
	endtask

	task automatic push_sample(input logic a, input logic b, input logic sw);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_a       <= a;
		line_b       <= b;
		switch_level <= sw;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		if (sent % 50 == 0)
			calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic push_lines(input logic a, input logic b, input int n);
		logic lvl;
		repeat (n) begin
			next_level(lvl);
			push_sample(a, b, lvl);
		end
	endtask

	task automatic noise(input int n);
		repeat (n) push_lines(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
	endtask

	// one detent: rest high, mostly long enough to qualify and re-arm, then turn
	task automatic turn_detent();
		int span;
		span = cur_thr + cur_rearm + 1;
		if ($urandom_range(0, 5) == 0)
			span = $urandom_range(0, span);
		else
			span += $urandom_range(2, 6);
		push_lines(1'b1, 1'b1, span);
		if ($urandom_range(0, 2) == 0)
			noise($urandom_range(1, 3));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				push_lines(1'b0, 1'b1, $urandom_range(1, 3));
				push_lines(1'b0, 1'b0, $urandom_range(1, 3));
				push_lines(1'b1, 1'b0, $urandom_range(1, 3));
			end
			4, 5, 6, 7: begin
				push_lines(1'b1, 1'b0, $urandom_range(1, 3));
				push_lines(1'b0, 1'b0, $urandom_range(1, 3));
				push_lines(1'b0, 1'b1, $urandom_range(1, 3));
			end
			8: push_lines(1'b0, 1'b0, $urandom_range(1, 3));
			default: noise($urandom_range(3, 12));
		endcase
	endtask

	task automatic run_until(input int goal);
		while (sent < goal)
			turn_detent();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] t, input logic [7:0] r,
			input logic [7:0] h);
		drain();
		cfg_index <= REG_DEBOUNCE_THRESHOLD;
		cfg_data  <= t;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_REARM_TICKS;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_SWITCH_HOLD_TICKS;
		cfg_data  <= h;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_thr   = t;
		cur_rearm = r;
		cur_hold  = h;
		settings++;
	endtask

	initial begin
		forever begin : receiver
			int gap;
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("rotary_encoder_button_qualifier verification failed");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 4; i++)
			push_sample(PRELUDE[3*(3-i)+2], PRELUDE[3*(3-i)+1], PRELUDE[3*(3-i)]);
		configure(8'd0, 8'd0, 8'd1);
		for (int i = 0; i < 20; i++)
			push_sample(OPENING[3*(19-i)+2], OPENING[3*(19-i)+1], OPENING[3*(19-i)]);
		run_until(sent + 150);

		configure(RST_DEBOUNCE_THRESHOLD, RST_REARM_TICKS, RST_SWITCH_HOLD_TICKS);
		run_until(sent + 200);

		configure(8'd3, 8'd5, 8'd4);
		run_until(sent + 120);
		drain();
		run_until(sent + 120);

		configure(8'd254, 8'd0, 8'd255);
		run_until(sent + 200);

		configure(8'd2, 8'd255, 8'($urandom_range(1, 40)));
		run_until(sent + 200);

		configure(8'($urandom_range(0, 20)), 8'($urandom_range(0, 30)),
			8'($urandom_range(1, 20)));
		run_until(sent + 100);

		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d samples: %0d left steps, %0d right steps, %0d presses",
			samples, lefts, rights, presses);
		$display("over %0d register settings, threshold 0..254, re-arm 0..255, hold 1..255",
			settings);
		if (errors == 0)
			$display("rotary_encoder_button_qualifier verification clean");
		else
			$display("rotary_encoder_button_qualifier verification failed");
		$finish;
	end

endmodule
